@@ rtl/dq_pkg.sv @@
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the bounded deque: command and status codes,
// cell chain operations and the sequencer states.
// ----------------------------------------------------------------------------
package dq_pkg;

  // Default geometry
  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;

  // Fixed field widths of the channels
  localparam int ACTION_W  = 3;
  localparam int OPERAND_W = 32;
  localparam int ITEM_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int OCC_W     = 5;

  // Command codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_DELETE     = 3'd4,
    ACT_READ_FIRST = 3'd5,
    ACT_READ_LAST  = 3'd6,
    ACT_CLEAR      = 3'd7
  } action_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Operation applied to every cell of the chain in the same cycle
  typedef enum logic [2:0] {
    CELL_HOLD,       // keep contents
    CELL_INS_FRONT,  // take left neighbor, cell 0 takes the new word
    CELL_LOAD,       // the cell at position count takes the new word
    CELL_ROT,        // rotate occupied run one place toward the front
    CELL_DROP        // shift toward the front, losing the head
  } cell_op_t;

  // Control bundle broadcast to the chain
  typedef struct packed {
    cell_op_t op;
  } cell_ctl_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_ROT,
    S_DEL,
    S_READ
  } state_t;

endpackage

@@ rtl/dq_if.sv @@
// ----------------------------------------------------------------------------
// dq_if
// Valid/ready channels of the deque: the command channel and the result
// channel, each with a source and a sink modport.
// ----------------------------------------------------------------------------
interface dq_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic [dq_pkg::ACTION_W-1:0]          action;
  logic signed [dq_pkg::OPERAND_W-1:0]  operand;

  modport source (output valid, action, operand, input ready);
  modport sink   (input valid, action, operand, output ready);
endinterface

interface dq_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dq_pkg::ITEM_W-1:0]     item_value;
  logic                                 has_value;
  logic [dq_pkg::STATUS_W-1:0]          status;
  logic [dq_pkg::OCC_W-1:0]             occupancy;
  logic                                 last_of_run;

  modport source (output valid, item_value, has_value, status, occupancy, last_of_run,
                  input ready);
  modport sink   (input valid, item_value, has_value, status, occupancy, last_of_run,
                  output ready);
endinterface

@@ rtl/dq_cell.sv @@
// ----------------------------------------------------------------------------
// dq_cell
// One storage cell of the deque chain. Holds the word at a fixed logical
// position and moves data to or from its neighbors as the broadcast op says.
// ----------------------------------------------------------------------------
module dq_cell #(
  parameter int VALUE_WIDTH = dq_pkg::VALUE_WIDTH,
  parameter int CNT_W       = 5,
  parameter int IDX         = 0
) (
  input  logic                   clk,
  input  dq_pkg::cell_ctl_t      ctl,
  input  logic [CNT_W-1:0]       count,
  input  logic [VALUE_WIDTH-1:0] new_word,
  input  logic [VALUE_WIDTH-1:0] head,
  input  logic [VALUE_WIDTH-1:0] left,
  input  logic [VALUE_WIDTH-1:0] right,
  output logic [VALUE_WIDTH-1:0] data
);

  logic at_tail;   // this cell is the last occupied one
  logic at_free;   // this cell is the first free one

  assign at_tail = (count == CNT_W'(IDX + 1));
  assign at_free = (count == CNT_W'(IDX));

  // Payload register, no reset
  always_ff @(posedge clk) begin
    case (ctl.op)
      dq_pkg::CELL_INS_FRONT: data <= left;
      dq_pkg::CELL_LOAD: begin
        if (at_free) data <= new_word;
      end
      dq_pkg::CELL_ROT:  data <= at_tail ? head : right;
      dq_pkg::CELL_DROP: data <= right;
      default:           data <= data;
    endcase
  end

endmodule

@@ rtl/bounded_deque_with_value_delete.sv @@
// ----------------------------------------------------------------------------
// bounded_deque_with_value_delete
// Bounded double-ended queue of signed words with delete-by-value, built as a
// chain of storage cells driven by a small sequencer.
// ----------------------------------------------------------------------------
// The store is a row of DEPTH cells, cell 0 holding the front entry; only the
// front cell is ever read out. Push front, push back, pop front, clear, pop back
// on an empty store and a read of zero entries are handled in the cycle they are
// accepted, without leaving the idle state. Every other command walks the
// occupied run around the chain one position per cycle, pausing only where a
// result must wait for the result register; a read of the first or last N
// entries emits one result per entry read. Each result waits in a single
// result register until it is taken. A new command is taken only when the
// sequencer is idle and the result register is free or being drained in the
// same cycle, so a receiver that holds off also stalls the command channel.
module bounded_deque_with_value_delete #(
  parameter int DEPTH       = dq_pkg::DEPTH,
  parameter int VALUE_WIDTH = dq_pkg::VALUE_WIDTH
) (
  input  logic           clk,
  input  logic           rst,
  dq_cmd_if.sink         cmd,
  dq_rsp_if.source       rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int EXT_W = (VALUE_WIDTH > dq_pkg::ITEM_W) ? VALUE_WIDTH : dq_pkg::ITEM_W;

  // Sequencer and occupancy state
  dq_pkg::state_t         state, state_next;
  logic [CNT_W-1:0]       count, count_next;
  logic [CNT_W-1:0]       step, step_next;
  logic [CNT_W-1:0]       rd_num, rd_num_next;
  logic                   rd_last, rd_last_next;
  logic [VALUE_WIDTH-1:0] del_word, del_word_next;

  // Result register
  logic                          out_valid;
  logic signed [dq_pkg::ITEM_W-1:0] out_item;
  logic                          out_has;
  dq_pkg::status_t               out_status;
  logic [dq_pkg::OCC_W-1:0]      out_occ;
  logic                          out_last;

  // Emission request from the sequencer
  logic            emit;
  logic            emit_has;
  dq_pkg::status_t emit_status;
  logic            emit_last;

  logic                   out_free;
  logic                   cmd_fire;
  dq_pkg::action_t        act;
  dq_pkg::cell_ctl_t      ctl;
  logic [VALUE_WIDTH-1:0] push_word;
  logic [VALUE_WIDTH-1:0] cell_q [DEPTH];
  logic [VALUE_WIDTH-1:0] head;
  logic signed [EXT_W-1:0] op_ext;
  logic signed [EXT_W-1:0] head_ext;
  logic [CNT_W-1:0]       rd_eff;
  logic                   full, empty;
  logic                   in_window, win_last;

  assign out_free = !out_valid || rsp.ready;
  assign cmd.ready = !rst && (state == dq_pkg::S_IDLE) && out_free;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign act       = dq_pkg::action_t'(cmd.action);

  // Operand to stored word, head word to result field (sign extend, then cut)
  assign op_ext    = EXT_W'(cmd.operand);
  assign push_word = op_ext[VALUE_WIDTH-1:0];
  assign head      = cell_q[0];
  assign head_ext  = EXT_W'($signed(head));

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);

  // Effective read count: negative is zero, saturate at occupancy
  always_comb begin
    if (cmd.operand[dq_pkg::OPERAND_W-1]) begin
      rd_eff = '0;
    end else if (32'(cmd.operand) > 32'(count)) begin
      rd_eff = count;
    end else begin
      rd_eff = cmd.operand[CNT_W-1:0];
    end
  end

  // Read window: which walk steps emit, and which one closes the run
  always_comb begin
    if (rd_last) begin
      in_window = (step >= (count - rd_num));
      win_last  = (step == (count - CNT_W'(1)));
    end else begin
      in_window = (step < rd_num);
      win_last  = (step == (rd_num - CNT_W'(1)));
    end
  end

  // Sequencer next state, chain control and result requests
  always_comb begin
    state_next    = state;
    count_next    = count;
    step_next     = step;
    rd_num_next   = rd_num;
    rd_last_next  = rd_last;
    del_word_next = del_word;
    ctl.op        = dq_pkg::CELL_HOLD;
    emit          = 1'b0;
    emit_has      = 1'b0;
    emit_status   = dq_pkg::ST_OK;
    emit_last     = 1'b1;

    case (state)
      dq_pkg::S_IDLE: begin
        if (cmd_fire) begin
          case (act)
            dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_BACK: begin
              emit = 1'b1;
              if (full) begin
                emit_status = dq_pkg::ST_FULL;
              end else begin
                ctl.op     = (act == dq_pkg::ACT_PUSH_FRONT) ? dq_pkg::CELL_INS_FRONT
                                                             : dq_pkg::CELL_LOAD;
                count_next = count + CNT_W'(1);
              end
            end
            dq_pkg::ACT_POP_FRONT: begin
              emit = 1'b1;
              if (empty) begin
                emit_status = dq_pkg::ST_EMPTY;
              end else begin
                emit_has   = 1'b1;
                ctl.op     = dq_pkg::CELL_DROP;
                count_next = count - CNT_W'(1);
              end
            end
            dq_pkg::ACT_POP_BACK: begin
              if (empty) begin
                emit        = 1'b1;
                emit_status = dq_pkg::ST_EMPTY;
              end else begin
                step_next  = count - CNT_W'(1);
                state_next = dq_pkg::S_ROT;
              end
            end
            dq_pkg::ACT_DELETE: begin
              del_word_next = push_word;
              step_next     = count;
              state_next    = dq_pkg::S_DEL;
            end
            dq_pkg::ACT_READ_FIRST, dq_pkg::ACT_READ_LAST: begin
              if (rd_eff == '0) begin
                emit        = 1'b1;
                emit_status = empty ? dq_pkg::ST_EMPTY : dq_pkg::ST_OK;
              end else begin
                rd_num_next  = rd_eff;
                rd_last_next = (act == dq_pkg::ACT_READ_LAST);
                step_next    = '0;
                state_next   = dq_pkg::S_READ;
              end
            end
            default: begin
              // clear
              emit       = 1'b1;
              count_next = '0;
            end
          endcase
        end
      end

      // Pop back: bring the tail to the front, then pop it
      dq_pkg::S_ROT: begin
        if (step != '0) begin
          ctl.op    = dq_pkg::CELL_ROT;
          step_next = step - CNT_W'(1);
        end else if (out_free) begin
          emit       = 1'b1;
          emit_has   = 1'b1;
          ctl.op     = dq_pkg::CELL_DROP;
          count_next = count - CNT_W'(1);
          state_next = dq_pkg::S_IDLE;
        end
      end

      // Delete value: each original entry passes the head once
      dq_pkg::S_DEL: begin
        if (step != '0) begin
          step_next = step - CNT_W'(1);
          if (head == del_word) begin
            ctl.op     = dq_pkg::CELL_DROP;
            count_next = count - CNT_W'(1);
          end else begin
            ctl.op = dq_pkg::CELL_ROT;
          end
        end else if (out_free) begin
          emit       = 1'b1;
          state_next = dq_pkg::S_IDLE;
        end
      end

      // Read: full rotation, emitting the head inside the window
      dq_pkg::S_READ: begin
        if (!in_window || out_free) begin
          ctl.op    = dq_pkg::CELL_ROT;
          step_next = step + CNT_W'(1);
          if (in_window) begin
            emit      = 1'b1;
            emit_has  = 1'b1;
            emit_last = win_last;
          end
          if (step == (count - CNT_W'(1))) state_next = dq_pkg::S_IDLE;
        end
      end

      default: state_next = dq_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dq_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Sequencer working registers
  always_ff @(posedge clk) begin
    step     <= step_next;
    rd_num   <= rd_num_next;
    rd_last  <= rd_last_next;
    del_word <= del_word_next;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item   <= emit_has ? head_ext[dq_pkg::ITEM_W-1:0] : '0;
      out_has    <= emit_has;
      out_status <= emit_status;
      out_occ    <= dq_pkg::OCC_W'(count_next);
      out_last   <= emit_last;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.item_value  = out_item;
  assign rsp.has_value   = out_has;
  assign rsp.status      = out_status;
  assign rsp.occupancy   = out_occ;
  assign rsp.last_of_run = out_last;

  // Cell chain
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_w;
    logic [VALUE_WIDTH-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = push_word;
    end else begin : g_mid_l
      assign left_w = cell_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_w = head;
    end else begin : g_mid_r
      assign right_w = cell_q[g+1];
    end

    dq_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CNT_W       (CNT_W),
      .IDX         (g)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .count    (count),
      .new_word (push_word),
      .head     (head),
      .left     (left_w),
      .right    (right_w),
      .data     (cell_q[g])
    );
  end

  // Assertions
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("result issued over a pending result");

  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && full && (act == dq_pkg::ACT_PUSH_FRONT || act == dq_pkg::ACT_PUSH_BACK))
    |=> (count == CNT_W'(DEPTH)))
    else $error("push into full store changed occupancy");

  a_read_stable: assert property (@(posedge clk) disable iff (rst)
    (state == dq_pkg::S_READ) |=> $stable(count))
    else $error("occupancy changed during read");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && act == dq_pkg::ACT_CLEAR) |=> (count == '0 && state == dq_pkg::S_IDLE))
    else $error("clear did not empty the store");

endmodule

@@ tb/bounded_deque_with_value_delete_test.sv @@
// ----------------------------------------------------------------------------
// bounded_deque_with_value_delete_test
// Self-checking bench for the bounded deque. A scripted opening covers empty
// and full stores, extreme words and counts, and multi-match deletes. A long
// random run follows, driven by the same transaction task, with random gaps on
// both channels and one long result back-pressure stretch. Every result is
// checked field by field against a queue-based prediction of the store or a typed-in value.
// ----------------------------------------------------------------------------
module bounded_deque_with_value_delete_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dq_pkg::*;

  localparam int RANDOM_ITEMS   = 405;
  localparam int QUIET_LIMIT    = 2000;  // cycles with no transaction on either side
  localparam int HOLD_AFTER     = 150;   // results seen before the long hold-off
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 40;

  // One result as it leaves the block
  typedef struct packed {
    logic signed [ITEM_W-1:0] item_value;
    logic                     has_value;
    status_t                  status;
    logic [OCC_W-1:0]         occupancy;
    logic                     last_of_run;
  } result_t;

  // One line of the opening script; reps repeats it with operand += stride
  typedef struct {
    action_t                     act;
    logic signed [OPERAND_W-1:0] opnd;
    int                          reps;
    int                          stride;
    bit                          fixed;
    result_t                     want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst;

  dq_cmd_if cmd_ch ();
  dq_rsp_if rsp_ch ();

  bounded_deque_with_value_delete DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  always #1 clk = ~clk;

  logic signed [ITEM_W-1:0] deque_model[$];   // front entry at index 0
  result_t                  step_results[$];  // results of the latest command
  result_t                  expected_results[$];
  script_row_t              script[$];
  int unsigned              fail_count = 0;
  bit                       sender_calm = 1'b0;

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Word to push or delete: a small pool so deletes hit, plus extremes
  function automatic logic signed [OPERAND_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return -32'sd1;
      3:       return 32'sd0;
      4, 5, 6: return $urandom_range(1, 6);
      default: return $urandom;
    endcase
  endfunction

  // Predict the results of one command and update the model store
  function automatic void predict_command(action_t act, logic signed [OPERAND_W-1:0] opnd);
    result_t                  r;
    logic signed [ITEM_W-1:0] kept[$];
    int                       n;
    int                       first;
    step_results.delete();
    r = '{item_value: '0, has_value: 1'b0, status: ST_OK, occupancy: '0, last_of_run: 1'b1};
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (deque_model.size() >= DEPTH) r.status = ST_FULL;
        else if (act == ACT_PUSH_FRONT) deque_model.push_front(opnd);
        else deque_model.push_back(opnd);
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (deque_model.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.has_value  = 1'b1;
          r.item_value = (act == ACT_POP_FRONT) ? deque_model.pop_front()
                                                : deque_model.pop_back();
        end
      end
      ACT_DELETE: begin
        foreach (deque_model[i])
          if (deque_model[i] != opnd) kept.push_back(deque_model[i]);
        deque_model = kept;
      end
      ACT_READ_FIRST, ACT_READ_LAST: begin
        if (opnd < 0) n = 0;
        else if (opnd > deque_model.size()) n = deque_model.size();
        else n = opnd;
        if (n == 0) begin
          if (deque_model.size() == 0) r.status = ST_EMPTY;
        end else begin
          first = (act == ACT_READ_FIRST) ? 0 : deque_model.size() - n;
          for (int i = 0; i < n; i++) begin
            r.has_value   = 1'b1;
            r.item_value  = deque_model[first + i];
            r.occupancy   = OCC_W'(deque_model.size());
            r.last_of_run = (i == n - 1);
            step_results.push_back(r);
          end
          return;
        end
      end
      default: deque_model.delete();
    endcase
    r.occupancy = OCC_W'(deque_model.size());
    step_results.push_back(r);
  endfunction

  // Script rows: predicted, or with the single result typed in
  function automatic void row_check(action_t a, logic signed [OPERAND_W-1:0] op,
                                    int reps = 1, int stride = 0);
    script_row_t row;
    row.act = a; row.opnd = op; row.reps = reps; row.stride = stride; row.fixed = 1'b0;
    row.want = '0;
    script.push_back(row);
  endfunction

  function automatic void row_fixed(action_t a, logic signed [OPERAND_W-1:0] op, logic h,
                                    logic signed [ITEM_W-1:0] v, status_t s, int occ);
    script_row_t row;
    row.act = a; row.opnd = op; row.reps = 1; row.stride = 0; row.fixed = 1'b1;
    row.want = '{item_value: v, has_value: h, status: s, occupancy: OCC_W'(occ),
                 last_of_run: 1'b1};
    script.push_back(row);
  endfunction

  // Random command, biased by the current fill so full and empty both occur
  function automatic void pick_random_command(output action_t act,
                                              output logic signed [OPERAND_W-1:0] opnd);
    int cnt;
    int r;
    int push_w;
    cnt    = deque_model.size();
    push_w = (cnt < 4) ? 55 : ((cnt > 12) ? 30 : 45);
    r      = $urandom_range(0, 99);
    if (r < push_w) begin
      act  = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
      opnd = pick_value();
    end else if (r < push_w + 20) begin
      act  = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;
      opnd = $urandom;
    end else if (r < push_w + 30) begin
      act = ACT_DELETE;
      if (cnt > 0 && $urandom_range(0, 4) != 0) opnd = deque_model[$urandom_range(0, cnt - 1)];
      else opnd = pick_value();
    end else if (r < 98) begin
      act = $urandom_range(0, 1) ? ACT_READ_LAST : ACT_READ_FIRST;
      case ($urandom_range(0, 9))
        7:       opnd = $urandom_range(0, 2);
        8, 9:    opnd = $urandom;                  // negative or far beyond the fill
        default: opnd = $urandom_range(0, DEPTH + 1);
      endcase
    end else begin
      act  = ACT_CLEAR;
      opnd = $urandom;
    end
  endfunction

  // Offer one command transaction and record its expected results on acceptance
  task automatic offer_command(action_t act, logic signed [OPERAND_W-1:0] opnd,
                               bit fixed, result_t want);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    repeat (gap) begin
      cmd_ch.valid   <= 1'b0;
      cmd_ch.action  <= ACTION_W'($urandom);
      cmd_ch.operand <= $urandom;
      @(posedge clk);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.action  <= act;
    cmd_ch.operand <= opnd;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    predict_command(act, opnd);
    if (fixed) expected_results.push_back(want);
    else foreach (step_results[i]) expected_results.push_back(step_results[i]);
  endtask

  // Stimulus: reset, opening script, random run, drain
  initial begin
    action_t                     act;
    logic signed [OPERAND_W-1:0] opnd;
    rst            = 1'b1;
    cmd_ch.valid   = 1'b0;
    cmd_ch.action  = ACT_PUSH_FRONT;
    cmd_ch.operand = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty store
    row_fixed(ACT_POP_FRONT,  0,              0, 0, ST_EMPTY, 0);
    row_fixed(ACT_POP_BACK,   0,              0, 0, ST_EMPTY, 0);
    row_fixed(ACT_READ_FIRST, 5,              0, 0, ST_EMPTY, 0);
    row_fixed(ACT_READ_LAST,  -1,             0, 0, ST_EMPTY, 0);
    row_fixed(ACT_DELETE,     0,              0, 0, ST_OK,    0);
    // extreme words, zero and negative counts
    row_fixed(ACT_PUSH_BACK,  32'sh7fff_ffff, 0, 0, ST_OK,    1);
    row_fixed(ACT_PUSH_FRONT, 32'sh8000_0000, 0, 0, ST_OK,    2);
    row_fixed(ACT_PUSH_BACK,  -1,             0, 0, ST_OK,    3);
    row_fixed(ACT_READ_FIRST, 0,              0, 0, ST_OK,    3);
    row_fixed(ACT_READ_LAST,  32'sh8000_0000, 0, 0, ST_OK,    3);
    row_check(ACT_READ_FIRST, 32'sh7fff_ffff);
    row_check(ACT_READ_LAST,  2);
    row_fixed(ACT_POP_BACK,   0,              1, -1,             ST_OK, 2);
    row_fixed(ACT_POP_FRONT,  0,              1, 32'sh8000_0000, ST_OK, 1);
    // fill up, then refused pushes at both ends
    row_check(ACT_PUSH_BACK,  100, DEPTH - 1, 1);
    row_fixed(ACT_PUSH_FRONT, 1,              0, 0, ST_FULL,  DEPTH);
    row_fixed(ACT_PUSH_BACK,  2,              0, 0, ST_FULL,  DEPTH);
    row_check(ACT_READ_LAST,  DEPTH);
    row_check(ACT_READ_FIRST, DEPTH + 1);
    // deletes: single match, no match, several matches
    row_fixed(ACT_DELETE,     100,            0, 0, ST_OK,    DEPTH - 1);
    row_fixed(ACT_DELETE,     100,            0, 0, ST_OK,    DEPTH - 1);
    row_check(ACT_POP_FRONT,  0);
    row_check(ACT_PUSH_FRONT, 9, 2, 0);
    row_fixed(ACT_DELETE,     9,              0, 0, ST_OK,    DEPTH - 2);
    row_check(ACT_READ_FIRST, 3);
    // clear, then reuse from the start
    row_fixed(ACT_CLEAR,      0,              0, 0, ST_OK,    0);
    row_fixed(ACT_POP_BACK,   0,              0, 0, ST_EMPTY, 0);
    row_check(ACT_PUSH_FRONT, -5);
    row_check(ACT_PUSH_BACK,  6);
    row_check(ACT_READ_LAST,  2);

    foreach (script[i])
      for (int r = 0; r < script[i].reps; r++)
        offer_command(script[i].act, script[i].opnd + r * script[i].stride,
                      script[i].fixed, script[i].want);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      sender_calm = (k >= 200 && k < 260);
      pick_random_command(act, opnd);
      offer_command(act, opnd, 1'b0, '0);
    end
    cmd_ch.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS bounded_deque_with_value_delete");
    end else begin
      $display("FAIL bounded_deque_with_value_delete");
    end
    $finish;
  end

  // Result side ready: gaps after transactions, one long hold-off, a calm stretch
  initial begin
    int gap_left;
    int hold_left;
    int seen;
    gap_left     = 0;
    hold_left    = 0;
    seen         = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen++;
        gap_left = (seen >= 500 && seen < 650) ? 0 : pick_gap();
        if (seen == HOLD_AFTER) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: value %0h has_value %0b status %0d occupancy %0d",
                 $time, rsp_ch.item_value, rsp_ch.has_value, rsp_ch.status,
                 rsp_ch.occupancy);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("item_value",  want.item_value,  rsp_ch.item_value);
        check_field("has_value",   want.has_value,   rsp_ch.has_value);
        check_field("status",      want.status,      rsp_ch.status);
        check_field("occupancy",   want.occupancy,   rsp_ch.occupancy);
        check_field("last_of_run", want.last_of_run, rsp_ch.last_of_run);
      end
    end
  end

  // Watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    int quiet;
    if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, quiet, expected_results.size());
      $display("FAIL bounded_deque_with_value_delete");
      $finish;
    end
  end

endmodule
